// ===== rtl/imuca_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared widths, codes, command and status types, and the arctangent table.
package imuca_pkg;

    localparam int GYRO_W     = 24;
    localparam int ACC_W      = 16;
    localparam int DT_W       = 20;
    localparam int ANG_W      = 32;
    localparam int GAIN_W     = 17;
    localparam int NORM_W     = 15;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;

    localparam int CORDIC_ITER_DEF = 16;
    localparam int ATAN_IDX_W      = 5;
    localparam int CORDIC_W        = 40;
    localparam int Z_W             = 32;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = 54;
    localparam int SEL_W   = 3;

    // Selects for the squaring pass.
    localparam int SQ_AX = 0;
    localparam int SQ_AY = 1;
    localparam int SQ_AZ = 2;
    localparam int SQ_LO = 3;
    localparam int SQ_HI = 4;

    // Axis selects; roll and pitch share the x and y codes.
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    localparam logic [GAIN_W-1:0]     GAIN_ONE = 17'd65536;
    localparam logic signed [Z_W-1:0] DEG180   = 32'sd11796480;
    localparam logic signed [Z_W-1:0] DEG360   = 32'sd23592960;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_GAIN  = 2'd0,
        CFG_BLEND_GAIN = 2'd1,
        CFG_NORM_LOW   = 2'd2,
        CFG_NORM_HIGH  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE        = 4'd0,
        OP_SQUARE      = 4'd1,
        OP_FILT        = 4'd2,
        OP_INTEG       = 4'd3,
        OP_WRAP        = 4'd4,
        OP_SQRT        = 4'd5,
        OP_CORDIC_INIT = 4'd6,
        OP_CORDIC_STEP = 4'd7,
        OP_BLEND_A     = 4'd8,
        OP_BLEND_B     = 4'd9,
        OP_EMIT        = 4'd10
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [SEL_W-1:0]      sel;
        logic [ATAN_IDX_W-1:0] iter;
        logic                  take;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic used;
        logic slot_free;
    } status_t;

    // Arctangent of 2^-i in degrees, Q16.
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            5'd17:   v = 32'sd29;
            5'd18:   v = 32'sd14;
            5'd19:   v = 32'sd7;
            5'd20:   v = 32'sd4;
            5'd21:   v = 32'sd2;
            5'd22:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/imuca_in_if.sv =====
`timescale 1ns / 1ps
// Interface: sample channel carrying one IMU word.
interface imuca_in_if;
    import imuca_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [GYRO_W-1:0] gyro_x;
    logic signed [GYRO_W-1:0] gyro_y;
    logic signed [GYRO_W-1:0] gyro_z;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
    logic [DT_W-1:0]          step_time;

    modport source (
        output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, step_time,
        input  ready
    );
    modport sink (
        input  valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, step_time,
        output ready
    );
endinterface

// ===== rtl/imuca_out_if.sv =====
`timescale 1ns / 1ps
// Interface: result channel carrying one attitude word.
interface imuca_out_if;
    import imuca_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ANG_W-1:0]  roll_angle;
    logic signed [ANG_W-1:0]  pitch_angle;
    logic signed [ANG_W-1:0]  yaw_angle;
    logic signed [GYRO_W-1:0] rate_x;
    logic signed [GYRO_W-1:0] rate_y;
    logic signed [GYRO_W-1:0] rate_z;
    logic                     estimate_valid;
    logic                     accel_used;

    modport source (
        output valid, roll_angle, pitch_angle, yaw_angle, rate_x, rate_y, rate_z,
               estimate_valid, accel_used,
        input  ready
    );
    modport sink (
        input  valid, roll_angle, pitch_angle, yaw_angle, rate_x, rate_y, rate_z,
               estimate_valid, accel_used,
        output ready
    );
endinterface

// ===== rtl/imuca_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences the operations of one sample through the datapath.
module imuca_ctrl #(
    parameter int CORDIC_ITERATIONS = imuca_pkg::CORDIC_ITER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  imuca_pkg::status_t status,
    output imuca_pkg::cmd_t    cmd
);
    import imuca_pkg::*;

    localparam int CNT_W = ($clog2(CORDIC_ITERATIONS) > 4) ? $clog2(CORDIC_ITERATIONS) : 4;
    localparam logic [CNT_W-1:0] SQ_LAST     = CNT_W'(SQ_HI);
    localparam logic [CNT_W-1:0] AXIS_LAST   = CNT_W'(AXIS_Z);
    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(15);
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_ITERATIONS - 1);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_SQUARE  = 12'b000000000010,
        S_FILT    = 12'b000000000100,
        S_INTEG   = 12'b000000001000,
        S_WRAP    = 12'b000000010000,
        S_SQRT    = 12'b000000100000,
        S_CINIT   = 12'b000001000000,
        S_CSTEP   = 12'b000010000000,
        S_BLEND_A = 12'b000100000000,
        S_BLEND_B = 12'b001000000000,
        S_FLUSH   = 12'b010000000000,
        S_OUT     = 12'b100000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             phase_reg, phase_next;
    logic [SEL_W-1:0] angle_sel;

    assign angle_sel = phase_reg ? SEL_W'(AXIS_Y) : SEL_W'(AXIS_X);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = '0;
        cmd.iter   = ATAN_IDX_W'(cnt_reg);
        cmd.take   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                cnt_next = '0;
                if (status.in_valid)
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.op  = OP_SQUARE;
                cmd.sel = SEL_W'(cnt_reg);
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_FILT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FILT:
            begin
                // The axes are filtered in the order they are integrated, so that each
                // filtered rate is written back before its integration reads it.
                cmd.op = OP_FILT;
                case (cnt_reg)
                    CNT_W'(0): cmd.sel = SEL_W'(AXIS_Z);
                    CNT_W'(1): cmd.sel = SEL_W'(AXIS_X);
                    default:   cmd.sel = SEL_W'(AXIS_Y);
                endcase
                if (cnt_reg == AXIS_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_INTEG;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_INTEG:
            begin
                // Yaw goes first so that its wrap can follow without waiting.
                cmd.op = OP_INTEG;
                case (cnt_reg)
                    CNT_W'(0): cmd.sel = SEL_W'(AXIS_Z);
                    CNT_W'(1): cmd.sel = SEL_W'(AXIS_X);
                    default:   cmd.sel = SEL_W'(AXIS_Y);
                endcase
                if (cnt_reg == AXIS_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_WRAP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WRAP:
            begin
                cmd.op     = OP_WRAP;
                phase_next = 1'b0;
                cnt_next   = '0;
                state_next = status.used ? S_SQRT : S_OUT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_CINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CINIT:
            begin
                cmd.op     = OP_CORDIC_INIT;
                cmd.sel    = angle_sel;
                cnt_next   = '0;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.op = OP_CORDIC_STEP;
                if (cnt_reg == CORDIC_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_BLEND_A;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_BLEND_A:
            begin
                cmd.op     = OP_BLEND_A;
                cmd.sel    = angle_sel;
                state_next = S_BLEND_B;
            end
            S_BLEND_B:
            begin
                cmd.op  = OP_BLEND_B;
                cmd.sel = angle_sel;
                if (phase_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_CINIT;
                end
            end
            S_FLUSH:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.slot_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end
endmodule

// ===== rtl/imuca_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration, estimator state, shared multiplier, square root and CORDIC.
module imuca_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [imuca_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [imuca_pkg::CFG_W-1:0]     cfg_data,
    input  imuca_pkg::cmd_t                cmd,
    output imuca_pkg::status_t             status,
    imuca_in_if.sink                       sample,
    imuca_out_if.source                    result
);
    import imuca_pkg::*;

    localparam logic signed [33:0] I_MAX = 34'sd2147483647;
    localparam logic signed [33:0] I_MIN = -34'sd2147483648;

    // Configuration
    logic [GAIN_W-1:0] rate_gain_reg, blend_gain_reg;
    logic [NORM_W-1:0] norm_low_reg, norm_high_reg;
    logic [GAIN_W-1:0] rate_g, blend_g;

    // Estimator state
    logic signed [GYRO_W-1:0] rate_reg [3];
    logic signed [ANG_W-1:0]  ang_reg [3];
    logic                     valid_flag_reg;

    // Latched sample
    logic signed [GYRO_W-1:0] gyro_reg [3];
    logic signed [ACC_W-1:0]  accel_reg [3];
    logic [DT_W-1:0]          dt_reg;

    // Scratch
    logic [31:0]              ax2_reg, rad_reg;
    logic [29:0]              lo2_reg, hi2_reg;
    logic [31:0]              sq_v_reg, sq_r_reg, sq_bit_reg;
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg;
    logic signed [Z_W-1:0]    cz_reg;
    logic                     czero_reg;
    logic signed [PROD_W-1:0] prod_reg, blend_acc_reg;
    op_t                      pend_op_reg;
    logic [SEL_W-1:0]         pend_sel_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [ANG_W-1:0]  out_ang_reg [3];
    logic signed [GYRO_W-1:0] out_rate_reg [3];
    logic                     out_est_reg, out_used_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [16:0]        sq_op;
    logic signed [GYRO_W:0]    f_diff;
    logic [GAIN_W:0]           blend_comp;
    logic signed [Z_W-1:0]     cz_eff;
    logic [32:0]               norm2;
    logic                      used;
    logic                      accept;
    logic [1:0]                cidx, pidx;

    logic signed [PROD_W-1:0]  f_round, i_round, b_sum;
    logic signed [33:0]        i_sum;
    logic signed [ANG_W-1:0]   i_sat;
    logic signed [ANG_W-1:0]   yaw_w1, yaw_w2;
    logic [31:0]               sq_rb;
    logic signed [17:0]        ci_x, ci_y, cn_x, cn_y;
    logic signed [Z_W-1:0]     ci_z;
    logic signed [CORDIC_W-1:0] c_dx, c_dy;
    logic signed [Z_W-1:0]     c_atan;

    assign rate_g  = (rate_gain_reg > GAIN_ONE) ? GAIN_ONE : rate_gain_reg;
    assign blend_g = (blend_gain_reg > GAIN_ONE) ? GAIN_ONE : blend_gain_reg;
    assign cidx    = cmd.sel[1:0];
    assign pidx    = pend_sel_reg[1:0];
    assign accept  = sample.valid && cmd.take;

    assign norm2 = {1'b0, ax2_reg} + {1'b0, rad_reg};
    assign used  = (norm2 > {3'b0, lo2_reg}) && (norm2 < {3'b0, hi2_reg});

    assign sample.ready     = cmd.take;
    assign status.in_valid  = sample.valid;
    assign status.used      = used;
    assign status.slot_free = !out_valid_reg || result.ready;

    assign result.valid          = out_valid_reg;
    assign result.roll_angle     = out_ang_reg[AXIS_X];
    assign result.pitch_angle    = out_ang_reg[AXIS_Y];
    assign result.yaw_angle      = out_ang_reg[AXIS_Z];
    assign result.rate_x         = out_rate_reg[AXIS_X];
    assign result.rate_y         = out_rate_reg[AXIS_Y];
    assign result.rate_z         = out_rate_reg[AXIS_Z];
    assign result.estimate_valid = out_est_reg;
    assign result.accel_used     = out_used_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.sel)
            SEL_W'(SQ_AX): sq_op = 17'(accel_reg[AXIS_X]);
            SEL_W'(SQ_AY): sq_op = 17'(accel_reg[AXIS_Y]);
            SEL_W'(SQ_AZ): sq_op = 17'(accel_reg[AXIS_Z]);
            SEL_W'(SQ_LO): sq_op = $signed({2'b00, norm_low_reg});
            default:       sq_op = $signed({2'b00, norm_high_reg});
        endcase
        f_diff     = (GYRO_W + 1)'(gyro_reg[cidx]) - (GYRO_W + 1)'(rate_reg[cidx]);
        blend_comp = {1'b0, GAIN_ONE} - {1'b0, blend_g};
        cz_eff     = czero_reg ? '0 : cz_reg;
        case (cmd.op)
            OP_SQUARE:
            begin
                mul_a = MUL_A_W'(sq_op);
                mul_b = MUL_B_W'(sq_op);
            end
            OP_FILT:
            begin
                mul_a = MUL_A_W'(f_diff);
                mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, rate_g});
            end
            OP_INTEG:
            begin
                mul_a = MUL_A_W'(rate_reg[cidx]);
                mul_b = $signed({{(MUL_B_W - DT_W){1'b0}}, dt_reg});
            end
            OP_BLEND_A:
            begin
                mul_a = MUL_A_W'(ang_reg[cidx]);
                mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, blend_g});
            end
            OP_BLEND_B:
            begin
                mul_a = MUL_A_W'(cz_eff);
                mul_b = $signed({{(MUL_B_W - GAIN_W - 1){1'b0}}, blend_comp});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Results of the registered product, and the non-multiplier steps.
    always_comb
    begin
        f_round = (prod_reg + PROD_W'(32768)) >>> 16;
        i_round = (prod_reg + PROD_W'(2048)) >>> 12;
        i_sum   = 34'(ang_reg[pidx]) + $signed(i_round[33:0]);
        if (i_sum > I_MAX)
        begin
            i_sat = 32'sh7FFFFFFF;
        end
        else if (i_sum < I_MIN)
        begin
            i_sat = 32'sh80000000;
        end
        else
        begin
            i_sat = i_sum[ANG_W-1:0];
        end
        b_sum = blend_acc_reg + prod_reg + PROD_W'(32768);

        yaw_w1 = (ang_reg[AXIS_Z] > DEG180) ? ang_reg[AXIS_Z] - DEG360 : ang_reg[AXIS_Z];
        yaw_w2 = (yaw_w1 < -DEG180) ? yaw_w1 + DEG360 : yaw_w1;

        sq_rb = sq_r_reg + sq_bit_reg;

        // Pre-rotation: a negative x turns by half a revolution.
        if (cmd.sel == SEL_W'(AXIS_X))
        begin
            ci_y = 18'(accel_reg[AXIS_Y]);
            ci_x = 18'(accel_reg[AXIS_Z]);
        end
        else
        begin
            ci_y = -18'(accel_reg[AXIS_X]);
            ci_x = $signed({1'b0, sq_r_reg[16:0]});
        end
        if (ci_x < 0)
        begin
            ci_z = (ci_y >= 0) ? DEG180 : -DEG180;
            cn_x = -ci_x;
            cn_y = -ci_y;
        end
        else
        begin
            ci_z = '0;
            cn_x = ci_x;
            cn_y = ci_y;
        end

        c_dx   = cy_reg >>> cmd.iter;
        c_dy   = cx_reg >>> cmd.iter;
        c_atan = atan_deg(cmd.iter);
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_gain_reg  <= GAIN_ONE;
            blend_gain_reg <= 17'd64225;
            norm_low_reg   <= 15'd5734;
            norm_high_reg  <= 15'd10650;
            for (int i = 0; i < 3; i++)
            begin
                rate_reg[i] <= '0;
                ang_reg[i]  <= '0;
            end
            valid_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_op_reg    <= OP_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_idx))
                    CFG_RATE_GAIN:  rate_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_BLEND_GAIN: blend_gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_NORM_LOW:   norm_low_reg   <= cfg_data[NORM_W-1:0];
                    CFG_NORM_HIGH:  norm_high_reg  <= cfg_data[NORM_W-1:0];
                    default:        ;
                endcase
            end

            pend_op_reg <= cmd.op;

            case (pend_op_reg)
                OP_FILT:    rate_reg[pidx] <= rate_reg[pidx] + f_round[GYRO_W-1:0];
                OP_INTEG:   ang_reg[pidx]  <= i_sat;
                OP_BLEND_B: ang_reg[pidx]  <= b_sum[ANG_W+15:16];
                default:    ;
            endcase

            if (cmd.op == OP_WRAP)
            begin
                ang_reg[AXIS_Z] <= yaw_w2;
            end

            if (cmd.op == OP_EMIT)
            begin
                valid_flag_reg <= valid_flag_reg || used;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scratch registers.
    always_ff @(posedge clk)
    begin
        prod_reg     <= mul_a * mul_b;
        pend_sel_reg <= cmd.sel;

        if (accept)
        begin
            gyro_reg[AXIS_X]  <= sample.gyro_x;
            gyro_reg[AXIS_Y]  <= sample.gyro_y;
            gyro_reg[AXIS_Z]  <= sample.gyro_z;
            accel_reg[AXIS_X] <= sample.accel_x;
            accel_reg[AXIS_Y] <= sample.accel_y;
            accel_reg[AXIS_Z] <= sample.accel_z;
            dt_reg            <= sample.step_time;
        end

        if (pend_op_reg == OP_SQUARE)
        begin
            case (pend_sel_reg)
                SEL_W'(SQ_AX): ax2_reg <= prod_reg[31:0];
                SEL_W'(SQ_AY): rad_reg <= prod_reg[31:0];
                SEL_W'(SQ_AZ):
                begin
                    rad_reg    <= rad_reg + prod_reg[31:0];
                    sq_v_reg   <= rad_reg + prod_reg[31:0];
                    sq_r_reg   <= '0;
                    sq_bit_reg <= 32'h40000000;
                end
                SEL_W'(SQ_LO): lo2_reg <= prod_reg[29:0];
                default:       hi2_reg <= prod_reg[29:0];
            endcase
        end

        if (pend_op_reg == OP_BLEND_A)
        begin
            blend_acc_reg <= prod_reg;
        end

        case (cmd.op)
            OP_SQRT:
            begin
                if (sq_v_reg >= sq_rb)
                begin
                    sq_v_reg <= sq_v_reg - sq_rb;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_CORDIC_INIT:
            begin
                czero_reg <= (ci_x == 0) && (ci_y == 0);
                cz_reg    <= ci_z;
                cx_reg    <= {{(CORDIC_W - 34){cn_x[17]}}, cn_x, 16'b0};
                cy_reg    <= {{(CORDIC_W - 34){cn_y[17]}}, cn_y, 16'b0};
            end
            OP_CORDIC_STEP:
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + c_dx;
                    cy_reg <= cy_reg - c_dy;
                    cz_reg <= cz_reg + c_atan;
                end
                else
                begin
                    cx_reg <= cx_reg - c_dx;
                    cy_reg <= cy_reg + c_dy;
                    cz_reg <= cz_reg - c_atan;
                end
            end
            OP_EMIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    out_ang_reg[i]  <= ang_reg[i];
                    out_rate_reg[i] <= rate_reg[i];
                end
                out_est_reg  <= valid_flag_reg || used;
                out_used_reg <= used;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/imu_complementary_attitude_unit.sv =====
`timescale 1ns / 1ps
// Top level: complementary-filter attitude estimator for one IMU word at a time.
//
//   channel   direction  handshake      word
//   sample    in         valid/ready    three gyro rates, three accelerations, step time
//   result    out        valid/ready    roll, pitch, yaw, filtered rates, flags
//   cfg       in         cfg_we only    register index and data, no read-back
//
// A sample whose acceleration misses the magnitude window goes from the yaw wrap straight
// to the output; one that passes first runs the 16-step square root and the two CORDIC
// runs with their blends, every product being formed on the single shared multiplier.
// Samples are taken one at a time: the block returns to idle once the result is emitted.
// The next sample is taken while the result still waits; a stalled result holds the
// block in its last step until the output register frees.
// Reset clears the estimate, the filtered rates and the valid flag, and loads the
// register defaults.
module imu_complementary_attitude_unit #(
    parameter int CORDIC_ITERATIONS = imuca_pkg::CORDIC_ITER_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [imuca_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [imuca_pkg::CFG_W-1:0]     cfg_data,
    imuca_in_if.sink                       sample,
    imuca_out_if.source                    result
);
    import imuca_pkg::*;

    cmd_t    cmd;
    status_t status;

    imuca_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    imuca_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .sample   (sample),
        .result   (result)
    );
endmodule

// ===== sim/imu_complementary_attitude_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench: drives IMU samples with random pacing, predicts each attitude word and checks it.
module imu_complementary_attitude_unit_tb;
    import imuca_pkg::*;

    localparam int  NUM_ITER     = 16;
    localparam int  HALF_PERIOD  = 6;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  CYCLE_LIMIT  = 1500000;
    localparam int  RANDOM_ITEMS = 1700;
    localparam longint HALF_TURN = 64'sd11796480;
    localparam longint FULL_TURN = 64'sd23592960;
    localparam longint UNITY     = 64'sd65536;

    typedef struct {
        logic signed [GYRO_W-1:0] gx, gy, gz;
        logic signed [ACC_W-1:0]  ax, ay, az;
        logic [DT_W-1:0]          dt;
    } imu_sample_t;

    typedef struct {
        logic signed [ANG_W-1:0]  roll, pitch, yaw;
        logic signed [GYRO_W-1:0] rx, ry, rz;
        logic                     est_valid;
        logic                     used;
    } attitude_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    imuca_in_if  sample ();
    imuca_out_if result ();

    imu_complementary_attitude_unit #(.CORDIC_ITERATIONS(NUM_ITER)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .sample   (sample),
        .result   (result)
    );

    always #HALF_PERIOD clk = ~clk;

    // Model state and register copies.
    longint rate_gain, blend_gain, norm_low, norm_high;
    int     roll_est, pitch_est, yaw_est;
    int     rate_x_f, rate_y_f, rate_z_f;
    bit     est_flag;
    longint arctan_q16 [0:29] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
        4, 2, 1, 0, 0, 0, 0, 0, 0, 0
    };

    attitude_t pending_attitude [$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  words_checked = 0;
    int  gated_words = 0;
    int  cycles = 0;
    int  burst_left = 0;
    bit  steady_sender = 1'b0;

    // Long receiver hold-off, counted in its own process.
    int  hold_len = 0;
    bit  hold_go = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;
    int  rx_mode = 0;
    int  rx_mode_left = 0;

    function automatic longint round_down_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint limit_gain(longint g);
        return (g > UNITY) ? UNITY : g;
    endfunction

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return int'(v);
    endfunction

    function automatic longint floor_root(longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < NUM_ITER && i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q16[i];
            end
        end
        return z;
    endfunction

    function automatic int smooth_rate(int prev, longint x);
        return int'(longint'(prev) + round_down_shift(limit_gain(rate_gain) * (x - prev), 16));
    endfunction

    function automatic int mix_angle(int angle, longint acc_angle);
        longint g;
        g = limit_gain(blend_gain);
        return int'(round_down_shift(g * angle + (UNITY - g) * acc_angle, 16));
    endfunction

    function automatic void clear_estimator();
        rate_gain  = 65536;
        blend_gain = 64225;
        norm_low   = 5734;
        norm_high  = 10650;
        roll_est = 0;
        pitch_est = 0;
        yaw_est = 0;
        rate_x_f = 0;
        rate_y_f = 0;
        rate_z_f = 0;
        est_flag = 1'b0;
    endfunction

    function automatic attitude_t advance_attitude(imu_sample_t s);
        attitude_t a;
        longint ax, ay, az, dt, norm2, radial;
        bit     gate;
        ax = s.ax;
        ay = s.ay;
        az = s.az;
        dt = longint'(s.dt);
        norm2 = ax * ax + ay * ay + az * az;
        gate = (norm2 > norm_low * norm_low) && (norm2 < norm_high * norm_high);

        rate_x_f = smooth_rate(rate_x_f, longint'(s.gx));
        rate_y_f = smooth_rate(rate_y_f, longint'(s.gy));
        rate_z_f = smooth_rate(rate_z_f, longint'(s.gz));

        roll_est  = clip32(longint'(roll_est)  + round_down_shift(longint'(rate_x_f) * dt, 12));
        pitch_est = clip32(longint'(pitch_est) + round_down_shift(longint'(rate_y_f) * dt, 12));
        yaw_est   = clip32(longint'(yaw_est)   + round_down_shift(longint'(rate_z_f) * dt, 12));

        if (gate)
        begin
            radial = floor_root(ay * ay + az * az);
            roll_est  = mix_angle(roll_est, vector_angle(ay, az));
            pitch_est = mix_angle(pitch_est, vector_angle(-ax, radial));
            est_flag  = 1'b1;
        end

        if (longint'(yaw_est) > HALF_TURN)
            yaw_est = int'(longint'(yaw_est) - FULL_TURN);
        if (longint'(yaw_est) < -HALF_TURN)
            yaw_est = int'(longint'(yaw_est) + FULL_TURN);

        a.roll = roll_est;
        a.pitch = pitch_est;
        a.yaw = yaw_est;
        a.rx = rate_x_f[GYRO_W-1:0];
        a.ry = rate_y_f[GYRO_W-1:0];
        a.rz = rate_z_f[GYRO_W-1:0];
        a.est_valid = est_flag;
        a.used = gate;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t on word %0d: %s got %0d expected %0d",
                 $realtime, words_checked, what, got, want);
        mismatches++;
    endtask

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= hold_len;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        attitude_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_attitude.size() == 0)
                report_mismatch("unexpected word", 0, 0);
            else
            begin
                want = pending_attitude.pop_front();
                if (result.roll_angle !== want.roll)
                    report_mismatch("roll_angle", result.roll_angle, want.roll);
                if (result.pitch_angle !== want.pitch)
                    report_mismatch("pitch_angle", result.pitch_angle, want.pitch);
                if (result.yaw_angle !== want.yaw)
                    report_mismatch("yaw_angle", result.yaw_angle, want.yaw);
                if (result.rate_x !== want.rx)
                    report_mismatch("rate_x", result.rate_x, want.rx);
                if (result.rate_y !== want.ry)
                    report_mismatch("rate_y", result.rate_y, want.ry);
                if (result.rate_z !== want.rz)
                    report_mismatch("rate_z", result.rate_z, want.rz);
                if (result.estimate_valid !== want.est_valid)
                    report_mismatch("estimate_valid", result.estimate_valid, want.est_valid);
                if (result.accel_used !== want.used)
                    report_mismatch("accel_used", result.accel_used, want.used);
                if (want.used)
                    gated_words++;
            end
            words_checked++;
        end
        if (rx_mode_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(20, 300);
        end
        else
            rx_mode_left <= rx_mode_left - 1;
        if (hold_left > 0)
            result.ready <= 1'b0;
        else
            case (rx_mode)
                0: result.ready <= 1'b1;
                1: result.ready <= ($urandom_range(0, 3) != 0);
                2: result.ready <= ($urandom_range(0, 3) == 0);
                default: result.ready <= cycles[2];
            endcase
    end

    // Sends one word, inserting a random gap at the start of each burst.
    task automatic send_sample(input imu_sample_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_sender ? 0 :
                  (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5));
            if (gap > 0)
            begin
                sample.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        sample.valid     <= 1'b1;
        sample.gyro_x    <= s.gx;
        sample.gyro_y    <= s.gy;
        sample.gyro_z    <= s.gz;
        sample.accel_x   <= s.ax;
        sample.accel_y   <= s.ay;
        sample.accel_z   <= s.az;
        sample.step_time <= s.dt;
        do
            @(posedge clk);
        while (!sample.ready);
        pending_attitude.push_back(advance_attitude(s));
        items_sent++;
        burst_left--;
    endtask

    task automatic send_fields(input int gx, input int gy, input int gz,
                               input int ax, input int ay, input int az, input int dt);
        imu_sample_t s;
        s.gx = gx;
        s.gy = gy;
        s.gz = gz;
        s.ax = ax;
        s.ay = ay;
        s.az = az;
        s.dt = dt;
        send_sample(s);
    endtask

    // Waits until the block has drained so that registers may be changed.
    task automatic wait_idle();
        sample.valid <= 1'b0;
        burst_left = 0;
        wait (pending_attitude.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_RATE_GAIN:  rate_gain  = value & 32'h1ffff;
            CFG_BLEND_GAIN: blend_gain = value & 32'h1ffff;
            CFG_NORM_LOW:   norm_low   = value & 32'h7fff;
            default:        norm_high  = value & 32'h7fff;
        endcase
    endtask

    task automatic set_registers(input int rg, input int bg, input int lo, input int hi);
        wait_idle();
        write_register(CFG_RATE_GAIN, rg);
        write_register(CFG_BLEND_GAIN, bg);
        write_register(CFG_NORM_LOW, lo);
        write_register(CFG_NORM_HIGH, hi);
    endtask

    function automatic imu_sample_t random_sample();
        imu_sample_t s;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            // Near one g in a random direction, moderate rates and short steps.
            s.gx = $urandom_range(0, 131071) - 65536;
            s.gy = $urandom_range(0, 131071) - 65536;
            s.gz = $urandom_range(0, 131071) - 65536;
            s.ax = $urandom_range(0, 9000) - 4500;
            s.ay = $urandom_range(0, 9000) - 4500;
            s.az = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(5000, 9000));
            s.dt = $urandom_range(0, 4096);
        end
        else
        begin
            s.gx = $urandom;
            s.gy = $urandom;
            s.gz = $urandom;
            s.ax = $urandom;
            s.ay = $urandom;
            s.az = $urandom;
            s.dt = (sel == 9) ? $urandom : $urandom_range(0, 65535);
        end
        return s;
    endfunction

    task automatic test_directed();
        send_fields(0, 0, 0, 0, 0, 0, 0);
        send_fields(8388607, 8388607, 8388607, 0, 0, 8192, 1048575);
        send_fields(-8388608, -8388608, -8388608, 0, 0, -8192, 1048575);
        send_fields(0, 0, 0, 0, -1, -8192, 100);
        send_fields(0, 0, 0, 0, 1, -8192, 100);
        send_fields(0, 0, 0, 8192, 0, 0, 0);
        send_fields(0, 0, 0, -8192, 0, 0, 0);
        send_fields(1000, -1000, 4000, -32768, -32768, -32768, 0);
        send_fields(1000, -1000, 4000, 32767, 32767, 32767, 0);
        send_fields(0, 0, 0, 0, 0, 5734, 10);
        send_fields(0, 0, 0, 0, 0, 5735, 10);
        send_fields(0, 0, 0, 0, 0, 10650, 10);
        send_fields(0, 0, 0, 0, 0, 10649, 10);
        send_fields(0, 0, 8388607, 0, 0, 0, 500000);
        send_fields(0, 0, -8388608, 0, 0, 0, 800000);
        send_fields(0, 0, -8388608, 0, 0, 0, 800000);
        send_fields(-5000, 5000, 0, 3000, -4000, 6000, 1048575);
        send_fields(0, 0, 0, 0, 8192, 0, 0);
    endtask

    task automatic test_register_extremes();
        set_registers(0, 0, 0, 32767);
        repeat (4) send_sample(random_sample());
        set_registers(65536, 65536, 32767, 0);
        repeat (4) send_sample(random_sample());
        // Gains above one behave as unity.
        set_registers(131071, 131071, 100, 20000);
        repeat (4) send_sample(random_sample());
        // An empty window never gates.
        set_registers(30000, 40000, 8192, 8192);
        repeat (4) send_sample(random_sample());
        set_registers(1, 1, 0, 1);
        send_fields(0, 0, 0, 0, 0, 0, 0);
        repeat (3) send_sample(random_sample());
        set_registers(65536, 64225, 5734, 10650);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_len <= 600;
        hold_go  <= ~hold_go;
        steady_sender = 1'b1;
        repeat (12) send_sample(random_sample());
        steady_sender = 1'b0;
        wait_idle();
    endtask

    task automatic test_random();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 249)
            begin
                if ($urandom_range(0, 1))
                    set_registers($urandom_range(0, 131071), $urandom_range(0, 131071),
                                  $urandom_range(0, 8000), $urandom_range(6000, 32767));
                else
                    set_registers($urandom_range(40000, 65536), $urandom_range(50000, 65536),
                                  $urandom_range(3000, 6000), $urandom_range(9000, 12000));
            end
            steady_sender = (n % 500) < 60;
            send_sample(random_sample());
        end
        sample.valid <= 1'b0;
    endtask

    initial
    begin
        sample.valid     = 1'b0;
        sample.gyro_x    = '0;
        sample.gyro_y    = '0;
        sample.gyro_z    = '0;
        sample.accel_x   = '0;
        sample.accel_y   = '0;
        sample.accel_z   = '0;
        sample.step_time = '0;
        result.ready     = 1'b0;
        clear_estimator();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random();

        wait (pending_attitude.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d samples and checked %0d attitude words, %0d of them accel-corrected.",
                 items_sent, words_checked, gated_words);
        $display("Covered register extremes, an empty gate window and a long output hold-off.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
